FILE: hdl/psp_pkg.sv
// ============================================================================
// psp_pkg: shared types and constants of the PPM stream parser
// Phase, result kind and error codes, the result record and the character
// constants and helpers of the header and sample tokenizer.
// ============================================================================
package psp_pkg;

    localparam int PSP_DIM_BITS = 16;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_WIDTH  = 3'd1,
        PH_HEIGHT = 3'd2,
        PH_MAXVAL = 3'd3,
        PH_DATA   = 3'd4,
        PH_HALT   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_FORMAT = 3'd0,
        KIND_WIDTH  = 3'd1,
        KIND_HEIGHT = 3'd2,
        KIND_MAXVAL = 3'd3,
        KIND_SAMPLE = 3'd4,
        KIND_RAW    = 3'd5,
        KIND_ERROR  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_MAGIC  = 3'd1,
        ERR_BAD_NUMBER = 3'd2,
        ERR_MAXVAL     = 3'd3,
        ERR_DIMENSION  = 3'd4,
        ERR_BAD_SAMPLE = 3'd5
    } err_t;

    localparam logic [1:0] DEPTH_ONE  = 2'd0;
    localparam logic [1:0] DEPTH_TWO  = 2'd1;
    localparam logic [1:0] DEPTH_FOUR = 2'd2;

    localparam logic FMT_BINARY = 1'b0;
    localparam logic FMT_ASCII  = 1'b1;

    localparam logic [7:0] CHR_P    = 8'h50;
    localparam logic [7:0] CHR_6    = 8'h36;
    localparam logic [7:0] CHR_3    = 8'h33;
    localparam logic [7:0] CHR_HASH = 8'h23;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_0    = 8'h30;
    localparam logic [7:0] CHR_9    = 8'h39;

    // Saturation point of the token accumulator: 2^32.
    localparam logic [32:0] TOKEN_SAT = 33'h1_0000_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        kind_t       item_kind;
        logic [31:0] item_value;
        logic [1:0]  sample_depth;
        logic [1:0]  channel;
        err_t        error_code;
        logic        last;
    } result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHR_0) && (b <= CHR_9);
    endfunction

    // value * 10 + digit, saturated at 2^32.
    function automatic logic [32:0] accum_digit(input logic [32:0] tv,
                                                input logic [7:0] b);
        logic [36:0] wide;
        logic [36:0] digit;
        digit = {33'd0, 4'(b - CHR_0)};
        wide  = ({4'd0, tv} << 3) + ({4'd0, tv} << 1) + digit;
        return (wide > {4'd0, TOKEN_SAT}) ? TOKEN_SAT : wide[32:0];
    endfunction

endpackage

FILE: hdl/ppm_stream_parser_unit.sv
// ============================================================================
// ppm_stream_parser_unit: PPM (P3 / P6) byte stream parser
// Tokenizes the header, reports format, width, height and maxval, then
// passes P6 bytes raw or P3 decimal samples, flagging the last data item.
// ============================================================================
// Path: a byte waits in the input register and its result in the result
// register before the result leaves the block; either register holds under a stall.
// Throughput: one byte per cycle while the result side keeps up; the parse
// core updates its state once for each byte that it consumes.
// Reset: synchronous on aresetn low; the parser returns to the magic phase
// with all counters cleared. A byte with file_start set restarts the parse.
// ============================================================================
module ppm_stream_parser_unit
    import psp_pkg::*;
#(
    parameter int DIM_BITS = PSP_DIM_BITS
)
(
    input  logic        aclk,
    input  logic        aresetn,

    // Input request channel: one file byte per request.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] file_start

    // Result request channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] item_value, [33:32] sample_depth,
                                   // [35:34] channel, [38:36] error_code,
                                   // [39] zero
    output logic [2:0]  m_tuser,   // [2:0] item_kind
    output logic        m_tlast    // last data item of the image
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     res_valid;
    result_t  res;
    logic     can_load;
    logic     step;
    result_t  m_res;

    assign s_item.data_byte  = s_tdata;
    assign s_item.file_start = s_tuser;

    // The held byte is consumed when it produces no result or the result
    // register is free (or being emptied) this cycle. This lets a byte enter
    // while a finished result still waits downstream.
    assign step = item_valid && (!res_valid || can_load);

    psp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .pop        (step),
        .item_valid (item_valid),
        .item       (item)
    );

    // The core computes the result of the held byte combinationally and
    // commits its state update only when the byte is consumed.
    psp_parse_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    psp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .load_res (res),
        .can_load (can_load),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {1'b0, m_res.error_code, m_res.channel, m_res.sample_depth,
                      m_res.item_value};
    assign m_tuser = m_res.item_kind;
    assign m_tlast = m_res.last;

endmodule

FILE: hdl/psp_in_stage.sv
// ============================================================================
// psp_in_stage: input register of the PPM stream parser
// Holds one accepted byte until the parse core consumes it.
// ============================================================================
module psp_in_stage
    import psp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     pop,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    // A new byte may enter when the register is empty or is drained now.
    assign s_ready    = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: hdl/psp_parse_core.sv
// ============================================================================
// psp_parse_core: tokenizer, header parser and image sample counter
// Updates the parse state for one byte and forms the result it causes.
// ============================================================================
module psp_parse_core
    import psp_pkg::*;
#(
    parameter int DIM_BITS = PSP_DIM_BITS
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step_en,
    input  in_item_t item,
    output logic     res_valid,
    output result_t  res
);

    phase_t              phase_reg,   phase_next;
    logic                fmt_reg,     fmt_next;
    logic                comment_reg, comment_next;
    logic                active_reg,  active_next;
    logic [32:0]         tv_reg,      tv_next;
    logic                bad_reg,     bad_next;
    logic [1:0]          magic_reg,   magic_next;
    logic [DIM_BITS-1:0] width_reg,   width_next;
    logic [DIM_BITS-1:0] height_reg,  height_next;
    logic [1:0]          depth_reg,   depth_next;
    logic [DIM_BITS-1:0] col_reg,     col_next;
    logic [DIM_BITS-1:0] row_reg,     row_next;
    logic [1:0]          chan_reg,    chan_next;
    logic [1:0]          bis_reg,     bis_next;

    logic [7:0] b;
    logic       feed;
    logic       final_sample;
    logic       last_byte;

    assign b = item.data_byte;

    always_comb begin
        // A file start restarts from the reset state before this byte.
        if (item.file_start) begin
            phase_next   = PH_MAGIC;
            fmt_next     = FMT_BINARY;
            comment_next = 1'b0;
            active_next  = 1'b0;
            tv_next      = '0;
            bad_next     = 1'b0;
            magic_next   = 2'd0;
            width_next   = '0;
            height_next  = '0;
            depth_next   = DEPTH_ONE;
            col_next     = '0;
            row_next     = '0;
            chan_next    = 2'd0;
            bis_next     = 2'd0;
        end else begin
            phase_next   = phase_reg;
            fmt_next     = fmt_reg;
            comment_next = comment_reg;
            active_next  = active_reg;
            tv_next      = tv_reg;
            bad_next     = bad_reg;
            magic_next   = magic_reg;
            width_next   = width_reg;
            height_next  = height_reg;
            depth_next   = depth_reg;
            col_next     = col_reg;
            row_next     = row_reg;
            chan_next    = chan_reg;
            bis_next     = bis_reg;
        end

        res_valid        = 1'b0;
        res              = '0;
        res.item_kind    = KIND_FORMAT;
        res.error_code   = ERR_NONE;
        feed             = 1'b0;

        final_sample = (chan_next == 2'd2) && (col_next == width_next - 1'b1) &&
                       (row_next == height_next - 1'b1);
        last_byte    = (depth_next == DEPTH_ONE) ||
                       (depth_next == DEPTH_TWO && bis_next == 2'd1) ||
                       (depth_next == DEPTH_FOUR && bis_next == 2'd3);

        unique case (phase_next)
            PH_DATA: begin
                if (fmt_next == FMT_BINARY) begin
                    res_valid        = 1'b1;
                    res.item_kind    = KIND_RAW;
                    res.item_value   = {24'd0, b};
                    res.sample_depth = depth_next;
                    res.channel      = chan_next;
                    res.last         = final_sample && last_byte;
                    if (last_byte) begin
                        bis_next = 2'd0;
                        if (chan_next == 2'd2) begin
                            chan_next = 2'd0;
                            if (col_next == width_next - 1'b1) begin
                                col_next = '0;
                                row_next = row_next + 1'b1;
                            end else begin
                                col_next = col_next + 1'b1;
                            end
                        end else begin
                            chan_next = chan_next + 2'd1;
                        end
                    end else begin
                        bis_next = bis_next + 2'd1;
                    end
                    if (final_sample && last_byte) begin
                        phase_next = PH_HALT;
                    end
                end else if (!is_ws(b)) begin
                    if (!active_next) begin
                        active_next = 1'b1;
                        tv_next     = '0;
                        bad_next    = 1'b0;
                        magic_next  = 2'd0;
                    end
                    if (is_digit(b)) begin
                        tv_next = accum_digit(tv_next, b);
                    end else begin
                        bad_next = 1'b1;
                    end
                end else if (active_next) begin
                    active_next = 1'b0;
                    res_valid   = 1'b1;
                    if (bad_next || tv_next[32]) begin
                        phase_next     = PH_HALT;
                        comment_next   = 1'b0;
                        res.item_kind  = KIND_ERROR;
                        res.error_code = ERR_BAD_SAMPLE;
                    end else begin
                        res.item_kind    = KIND_SAMPLE;
                        res.sample_depth = depth_next;
                        res.channel      = chan_next;
                        res.last         = final_sample;
                        if (depth_next == DEPTH_ONE) begin
                            res.item_value = {24'd0, tv_next[7:0]};
                        end else if (depth_next == DEPTH_TWO) begin
                            res.item_value = {16'd0, tv_next[15:0]};
                        end else begin
                            res.item_value = tv_next[31:0];
                        end
                        if (chan_next == 2'd2) begin
                            chan_next = 2'd0;
                            if (col_next == width_next - 1'b1) begin
                                col_next = '0;
                                row_next = row_next + 1'b1;
                            end else begin
                                col_next = col_next + 1'b1;
                            end
                        end else begin
                            chan_next = chan_next + 2'd1;
                        end
                        if (final_sample) begin
                            phase_next = PH_HALT;
                        end
                    end
                end
            end
            PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                if (comment_next) begin
                    if (b == CHR_LF) begin
                        comment_next = 1'b0;
                    end
                end else if (!active_next) begin
                    if (b == CHR_HASH) begin
                        comment_next = 1'b1;
                    end else if (!is_ws(b)) begin
                        active_next = 1'b1;
                        tv_next     = '0;
                        bad_next    = 1'b0;
                        magic_next  = 2'd0;
                        feed        = 1'b1;
                    end
                end else if (is_ws(b)) begin
                    // The whitespace byte ends a header token.
                    active_next = 1'b0;
                    res_valid   = 1'b1;
                    if (phase_next == PH_MAGIC) begin
                        if (bad_next || magic_next != 2'd2) begin
                            phase_next     = PH_HALT;
                            comment_next   = 1'b0;
                            res.item_kind  = KIND_ERROR;
                            res.error_code = ERR_BAD_MAGIC;
                        end else begin
                            phase_next     = PH_WIDTH;
                            res.item_kind  = KIND_FORMAT;
                            res.item_value = {31'd0, fmt_next};
                        end
                    end else if (bad_next) begin
                        phase_next     = PH_HALT;
                        comment_next   = 1'b0;
                        res.item_kind  = KIND_ERROR;
                        res.error_code = ERR_BAD_NUMBER;
                    end else if (phase_next == PH_WIDTH || phase_next == PH_HEIGHT) begin
                        if ((tv_next >> DIM_BITS) != '0) begin
                            phase_next     = PH_HALT;
                            comment_next   = 1'b0;
                            res.item_kind  = KIND_ERROR;
                            res.error_code = ERR_DIMENSION;
                        end else begin
                            res.item_value = tv_next[31:0];
                            if (phase_next == PH_WIDTH) begin
                                width_next    = tv_next[DIM_BITS-1:0];
                                phase_next    = PH_HEIGHT;
                                res.item_kind = KIND_WIDTH;
                            end else begin
                                height_next   = tv_next[DIM_BITS-1:0];
                                phase_next    = PH_MAXVAL;
                                res.item_kind = KIND_HEIGHT;
                            end
                        end
                    end else if (tv_next[32]) begin
                        phase_next     = PH_HALT;
                        comment_next   = 1'b0;
                        res.item_kind  = KIND_ERROR;
                        res.error_code = ERR_MAXVAL;
                    end else begin
                        if (tv_next < 33'd256) begin
                            depth_next = DEPTH_ONE;
                        end else if (tv_next < 33'd65536) begin
                            depth_next = DEPTH_TWO;
                        end else begin
                            depth_next = DEPTH_FOUR;
                        end
                        col_next  = '0;
                        row_next  = '0;
                        chan_next = 2'd0;
                        bis_next  = 2'd0;
                        // An empty image has no data phase at all.
                        if (width_next == '0 || height_next == '0) begin
                            phase_next = PH_HALT;
                        end else begin
                            phase_next = PH_DATA;
                        end
                        res.item_kind    = KIND_MAXVAL;
                        res.item_value   = tv_next[31:0];
                        res.sample_depth = depth_next;
                    end
                end else begin
                    feed = 1'b1;
                end

                if (feed) begin
                    if (phase_next == PH_MAGIC) begin
                        if (magic_next == 2'd0 && b == CHR_P) begin
                            magic_next = 2'd1;
                        end else if (magic_next == 2'd1 && (b == CHR_6 || b == CHR_3)) begin
                            fmt_next   = (b == CHR_3) ? FMT_ASCII : FMT_BINARY;
                            magic_next = 2'd2;
                        end else begin
                            bad_next = 1'b1;
                        end
                    end else if (is_digit(b)) begin
                        tv_next = accum_digit(tv_next, b);
                    end else begin
                        bad_next = 1'b1;
                    end
                end
            end
            default: begin
                // Halted: bytes are ignored until the next file start.
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MAGIC;
            fmt_reg     <= FMT_BINARY;
            comment_reg <= 1'b0;
            active_reg  <= 1'b0;
            tv_reg      <= '0;
            bad_reg     <= 1'b0;
            magic_reg   <= 2'd0;
            width_reg   <= '0;
            height_reg  <= '0;
            depth_reg   <= DEPTH_ONE;
            col_reg     <= '0;
            row_reg     <= '0;
            chan_reg    <= 2'd0;
            bis_reg     <= 2'd0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            fmt_reg     <= fmt_next;
            comment_reg <= comment_next;
            active_reg  <= active_next;
            tv_reg      <= tv_next;
            bad_reg     <= bad_next;
            magic_reg   <= magic_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            depth_reg   <= depth_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            chan_reg    <= chan_next;
            bis_reg     <= bis_next;
        end
    end

endmodule

FILE: hdl/psp_out_stage.sv
// ============================================================================
// psp_out_stage: result register of the PPM stream parser
// Holds one result until the downstream side takes it.
// ============================================================================
module psp_out_stage
    import psp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_res,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

endmodule

FILE: test/ppm_stream_parser_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// ppm_stream_parser_unit_tb: self-checking bench for the PPM stream parser
// Feeds PPM files one byte per request: directed headers, comments, samples
// and fault cases first, then random well-formed files with corruption and
// noise under varying source gaps and sink back-pressure. A byte-level parser
// kept in the bench predicts every result, and the results are compared
// field by field as they leave the block.
// ============================================================================
module ppm_stream_parser_unit_tb
    import psp_pkg::*;
();

    localparam int          DW           = PSP_DIM_BITS;
    localparam logic [32:0] DIM_MAX      = (33'd1 << DW) - 33'd1;
    localparam logic [32:0] WORD_MAX     = 33'h0_FFFF_FFFF;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 16;

    // Progress through the two magic characters.
    localparam logic [1:0] MAGIC_NONE = 2'd0;
    localparam logic [1:0] MAGIC_P    = 2'd1;
    localparam logic [1:0] MAGIC_DONE = 2'd2;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Traffic shaping, shared by the sender task and the sink process.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int          hold_left      = 0;

    int          mismatches     = 0;
    int          bytes_sent     = 0;
    int          quiet_cycles   = 0;

    result_t     due_items[$];
    logic [7:0]  file_buf[$];

    // Bench copy of the parser state.
    phase_t          pp_phase;
    logic            pp_format;
    logic            pp_comment;
    logic            pp_tok_on;
    logic [32:0]     pp_tok_val;
    logic            pp_tok_bad;
    logic [1:0]      pp_magic;
    logic [DW-1:0]   pp_width;
    logic [DW-1:0]   pp_height;
    logic [1:0]      pp_depth;
    logic [DW-1:0]   pp_col;
    logic [DW-1:0]   pp_row;
    logic [1:0]      pp_chan;
    logic [1:0]      pp_byte_idx;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ppm_stream_parser_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------
    // Byte-level parser used to predict the block's results.
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        pp_phase    = PH_MAGIC;
        pp_format   = FMT_BINARY;
        pp_comment  = 1'b0;
        pp_tok_on   = 1'b0;
        pp_tok_val  = '0;
        pp_tok_bad  = 1'b0;
        pp_magic    = MAGIC_NONE;
        pp_width    = '0;
        pp_height   = '0;
        pp_depth    = DEPTH_ONE;
        pp_col      = '0;
        pp_row      = '0;
        pp_chan     = 2'd0;
        pp_byte_idx = 2'd0;
    endfunction

    function automatic logic blank(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic void open_token();
        pp_tok_on  = 1'b1;
        pp_tok_val = '0;
        pp_tok_bad = 1'b0;
        pp_magic   = MAGIC_NONE;
    endfunction

    // Decimal accumulation, pinned at 2^32 so oversize values stay oversize.
    function automatic void take_digit(input logic [7:0] b);
        logic [36:0] v;
        if (b >= CHR_0 && b <= CHR_9) begin
            v = {4'd0, pp_tok_val} * 37'd10 + {33'd0, b[3:0]};
            pp_tok_val = (v > {4'd0, TOKEN_SAT}) ? TOKEN_SAT : v[32:0];
        end else begin
            pp_tok_bad = 1'b1;
        end
    endfunction

    function automatic void raise_error(input err_t code, output result_t r);
        pp_phase     = PH_HALT;
        pp_tok_on    = 1'b0;
        pp_comment   = 1'b0;
        r            = '0;
        r.item_kind  = KIND_ERROR;
        r.error_code = code;
    endfunction

    function automatic logic on_final_sample();
        return pp_chan == 2'd2 && pp_col == pp_width - 1'b1 && pp_row == pp_height - 1'b1;
    endfunction

    function automatic void next_sample();
        pp_chan = pp_chan + 2'd1;
        if (pp_chan == 2'd3) begin
            pp_chan = 2'd0;
            pp_col  = pp_col + 1'b1;
            if (pp_col >= pp_width) begin
                pp_col = '0;
                pp_row = pp_row + 1'b1;
            end
        end
    endfunction

    // Advances the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit ppm_parse_byte(input logic [7:0] b, input logic fresh,
                                          output result_t r);
        int   nbytes;
        logic fin;
        r = '0;
        if (fresh)
            clear_parser();

        if (pp_phase == PH_DATA) begin
            r.sample_depth = pp_depth;
            r.channel      = pp_chan;
            if (pp_format == FMT_BINARY) begin
                nbytes = (pp_depth == DEPTH_ONE) ? 1 : ((pp_depth == DEPTH_TWO) ? 2 : 4);
                fin = on_final_sample() && (int'(pp_byte_idx) + 1 >= nbytes);
                if (int'(pp_byte_idx) + 1 >= nbytes) begin
                    pp_byte_idx = 2'd0;
                    next_sample();
                end else begin
                    pp_byte_idx = pp_byte_idx + 2'd1;
                end
                if (fin)
                    pp_phase = PH_HALT;
                r.item_kind  = KIND_RAW;
                r.item_value = {24'd0, b};
                r.last       = fin;
                return 1'b1;
            end
            // Text samples: no comments allowed, a '#' is simply a bad digit.
            if (!blank(b)) begin
                if (!pp_tok_on)
                    open_token();
                take_digit(b);
                return 1'b0;
            end
            if (!pp_tok_on)
                return 1'b0;
            pp_tok_on = 1'b0;
            if (pp_tok_bad || pp_tok_val > WORD_MAX) begin
                raise_error(ERR_BAD_SAMPLE, r);
                return 1'b1;
            end
            fin = on_final_sample();
            next_sample();
            if (fin)
                pp_phase = PH_HALT;
            r.item_kind = KIND_SAMPLE;
            if (pp_depth == DEPTH_ONE)
                r.item_value = {24'd0, pp_tok_val[7:0]};
            else if (pp_depth == DEPTH_TWO)
                r.item_value = {16'd0, pp_tok_val[15:0]};
            else
                r.item_value = pp_tok_val[31:0];
            r.last = fin;
            return 1'b1;
        end

        if (pp_phase > PH_MAXVAL)
            return 1'b0;

        if (pp_comment) begin
            if (b == CHR_LF)
                pp_comment = 1'b0;
            return 1'b0;
        end

        if (!pp_tok_on) begin
            if (b == CHR_HASH) begin
                pp_comment = 1'b1;
                return 1'b0;
            end
            if (blank(b))
                return 1'b0;
            open_token();
        end else if (blank(b)) begin
            // The separator closes a header token.
            pp_tok_on = 1'b0;
            if (pp_phase == PH_MAGIC) begin
                if (pp_tok_bad || pp_magic != MAGIC_DONE) begin
                    raise_error(ERR_BAD_MAGIC, r);
                    return 1'b1;
                end
                pp_phase     = PH_WIDTH;
                r.item_kind  = KIND_FORMAT;
                r.item_value = {31'd0, pp_format};
                return 1'b1;
            end
            if (pp_tok_bad) begin
                raise_error(ERR_BAD_NUMBER, r);
                return 1'b1;
            end
            if (pp_phase != PH_MAXVAL) begin
                if (pp_tok_val > DIM_MAX) begin
                    raise_error(ERR_DIMENSION, r);
                    return 1'b1;
                end
                if (pp_phase == PH_WIDTH) begin
                    pp_width    = pp_tok_val[DW-1:0];
                    r.item_kind = KIND_WIDTH;
                    pp_phase    = PH_HEIGHT;
                end else begin
                    pp_height   = pp_tok_val[DW-1:0];
                    r.item_kind = KIND_HEIGHT;
                    pp_phase    = PH_MAXVAL;
                end
                r.item_value = pp_tok_val[31:0];
                return 1'b1;
            end
            if (pp_tok_val > WORD_MAX) begin
                raise_error(ERR_MAXVAL, r);
                return 1'b1;
            end
            if (pp_tok_val < 33'd256)
                pp_depth = DEPTH_ONE;
            else if (pp_tok_val < 33'd65536)
                pp_depth = DEPTH_TWO;
            else
                pp_depth = DEPTH_FOUR;
            pp_col      = '0;
            pp_row      = '0;
            pp_chan     = 2'd0;
            pp_byte_idx = 2'd0;
            // An empty image has nothing to stream after the maxval.
            if (pp_width == '0 || pp_height == '0)
                pp_phase = PH_HALT;
            else
                pp_phase = PH_DATA;
            r.item_kind    = KIND_MAXVAL;
            r.item_value   = pp_tok_val[31:0];
            r.sample_depth = pp_depth;
            return 1'b1;
        end

        if (pp_phase == PH_MAGIC) begin
            if (pp_magic == MAGIC_NONE && b == CHR_P) begin
                pp_magic = MAGIC_P;
            end else if (pp_magic == MAGIC_P && (b == CHR_6 || b == CHR_3)) begin
                pp_format = (b == CHR_3) ? FMT_ASCII : FMT_BINARY;
                pp_magic  = MAGIC_DONE;
            end else begin
                pp_tok_bad = 1'b1;
            end
        end else begin
            take_digit(b);
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one byte per request, with random gaps before each one.
    // The expectation is computed at the edge where the byte is taken.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fresh);
        result_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fresh;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (ppm_parse_byte(b, fresh, r))
            due_items.insert(due_items.size(), r);
        bytes_sent++;
    endtask

    // The first byte of the text starts a new file when fresh is set.
    task automatic send_text(input string txt, input logic fresh);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], fresh && i == 0);
    endtask

    // ------------------------------------------------------------------
    // Random file builder.
    // ------------------------------------------------------------------
    function automatic void buf_add(input logic [7:0] c);
        file_buf.insert(file_buf.size(), c);
    endfunction

    function automatic logic [7:0] any_blank();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'd32 : 8'd9 + 8'(k);
    endfunction

    function automatic void push_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            buf_add(txt[i]);
    endfunction

    // Decimal text, now and then with leading zeros.
    function automatic void push_num(input logic [31:0] v);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) buf_add(CHR_0);
        push_text($sformatf("%0d", v));
    endfunction

    // Whitespace run; in the header it may carry a comment line.
    function automatic void push_gap(input bit with_comment);
        logic [7:0] c;
        repeat ($urandom_range(1, 3)) buf_add(any_blank());
        if (with_comment && $urandom_range(0, 4) == 0) begin
            buf_add(CHR_HASH);
            repeat ($urandom_range(0, 6)) begin
                c = 8'($urandom_range(0, 255));
                buf_add((c == CHR_LF) ? 8'd32 : c);
            end
            buf_add(CHR_LF);
            if ($urandom_range(0, 1) == 1)
                buf_add(any_blank());
        end
    endfunction

    task automatic random_file();
        int unsigned w;
        int unsigned h;
        int unsigned nbytes;
        int unsigned pick;
        int unsigned cut;
        logic [31:0] maxval;
        logic [31:0] pix;
        logic        ascii;
        file_buf.delete();
        ascii = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            push_gap(1'b1);
        push_text(ascii ? "P3" : "P6");
        push_gap(1'b1);

        // Mostly tiny images; a few empty ones reach the largest dimension.
        w    = $urandom_range(1, 3);
        h    = $urandom_range(1, 3);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            w = 0;
            h = $urandom_range(0, 65535);
        end else if (pick == 1) begin
            w = 65535;
            h = 0;
        end
        push_num(w);
        push_gap(1'b1);
        push_num(h);
        push_gap(1'b1);

        case ($urandom_range(0, 5))
            0: maxval = $urandom_range(0, 255);
            1: maxval = $urandom_range(256, 65535);
            2: maxval = $urandom_range(65536, 32'hFFFF_FFFF);
            3: begin
                case ($urandom_range(0, 4))
                    0: maxval = 32'd255;
                    1: maxval = 32'd256;
                    2: maxval = 32'd65535;
                    3: maxval = 32'd65536;
                    default: maxval = 32'hFFFF_FFFF;
                endcase
            end
            default: maxval = 32'd255;
        endcase
        nbytes = (maxval < 256) ? 1 : ((maxval < 65536) ? 2 : 4);
        push_num(maxval);
        buf_add(any_blank());

        if (w * h > 0 && w * h <= 16) begin
            for (int i = 0; i < int'(w * h * 3); i++) begin
                if (!ascii) begin
                    repeat (nbytes) buf_add(8'($urandom_range(0, 255)));
                end else begin
                    pix = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, maxval);
                    push_num(pix);
                    push_gap(1'b0);
                end
            end
        end

        // Some files get a flipped byte or are cut short, some get trailing junk.
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick < 14) begin
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut)
                void'(file_buf.pop_back());
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) buf_add(8'($urandom_range(0, 255)));

        foreach (file_buf[i])
            send_byte(file_buf[i], i == 0);
    endtask

    task automatic run_random_phase(input int unsigned src, input int unsigned sink,
                                    input int budget, input bit hold);
        int stop_at;
        src_idle_pct   = src;
        sink_stall_pct = sink;
        if (hold)
            hold_request = 1'b1;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // Raw noise, occasionally marked as the start of a file.
                repeat ($urandom_range(4, 16))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end else begin
                random_file();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // P6 at all three sample depths; data bytes include all-zero, all-one and alternating bit patterns.
    task automatic test_binary_data();
        send_text("P6\n2 1\n255\n", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_text("ZZ", 1'b0);
        send_text("P6 1 1 256 ", 1'b1);
        repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_text("P6 1 1 4294967295\n", 1'b1);
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // P3 with comments, every whitespace kind and sample truncation.
    task automatic test_ascii_data();
        send_text("# lead\nP3\t1 2\n# dims\n65535", 1'b1);
        send_byte(8'h0D, 1'b0);
        send_text("70000 0 00042", 1'b0);
        send_byte(8'h0B, 1'b0);
        send_text("4294967295", 1'b0);
        send_byte(8'h0C, 1'b0);
        send_text("1 65536 7 ", 1'b0);
        send_text("P3 1 1 4294967295 4294967295 0 7 ", 1'b1);
    endtask

    // Every header fault; bytes after a fault are ignored until a new file.
    task automatic test_header_faults();
        send_text("P5 ", 1'b1);
        send_text("P63 1 1 255 ", 1'b1);
        send_text("p6 ", 1'b1);
        send_text("P6#\n", 1'b1);
        send_text("P6 1x ", 1'b1);
        send_text("P6 65536 ", 1'b1);
        send_text("P3 1 65536 ", 1'b1);
        send_text("P6 2 2 4294967296 ", 1'b1);
        send_text("P6 2 2 99999999999999999999 ", 1'b1);
        send_text("P6 1 1 25a 1 2 3 ", 1'b1);
    endtask

    // Bad text samples: a non-digit, a lone '#', and a value past 32 bits.
    task automatic test_sample_faults();
        send_text("P3 1 1 255 12#\n", 1'b1);
        send_text("P3 1 1 255 #\n", 1'b1);
        send_text("P3 2 1 255 4294967296 ", 1'b1);
        send_text("P3 1 1 255 1 2 3\n9 ", 1'b1);
    endtask

    // Empty images at the largest dimension, and restarts mid-file.
    task automatic test_empty_and_restart();
        send_text("P6 65535 0 255 abc", 1'b1);
        send_text("P3 0 65535 0 12 ", 1'b1);
        send_text("P6 2 2 255 ", 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_text("P6 12", 1'b1);
        send_text("P6 1 1 255 xyz", 1'b1);
    endtask

    // The sink holds off for a long stretch while bytes keep coming.
    task automatic test_long_stall();
        run_random_phase(0, 0, 80, 1'b1);
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 195, 1'b0);
        run_random_phase(47, 0, 195, 1'b0);
        run_random_phase(0, 47, 195, 1'b0);
        run_random_phase(25, 25, 195, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sink: random stalls, plus a long hold-off counted here on request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Every result taken from the block is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_items.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d value 0x%0h",
                         $time, m_tuser, m_tdata[31:0]);
                mismatches++;
            end else begin
                want = due_items.pop_front();
                check_field("item_kind", 32'(want.item_kind), 32'(m_tuser));
                check_field("item_value", want.item_value, m_tdata[31:0]);
                check_field("sample_depth", 32'(want.sample_depth), 32'(m_tdata[33:32]));
                check_field("channel", 32'(want.channel), 32'(m_tdata[35:34]));
                check_field("error_code", 32'(want.error_code), 32'(m_tdata[38:36]));
                check_field("pad", 32'd0, 32'(m_tdata[39]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Watchdog: cycles with work outstanding but no handshake on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && due_items.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ppm_stream_parser_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_binary_data();
        test_ascii_data();
        test_header_faults();
        test_sample_faults();
        test_empty_and_restart();
        test_long_stall();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (due_items.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("ppm_stream_parser_unit regression: pass");
        end else begin
            $display("ppm_stream_parser_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/psp_pkg.sv
hdl/psp_in_stage.sv
hdl/psp_parse_core.sv
hdl/psp_out_stage.sv
hdl/ppm_stream_parser_unit.sv
test/ppm_stream_parser_unit_tb.sv
